// File: src/rbp_pkg.sv
`default_nettype none
package rbp_pkg;

    localparam int MAX_DEGREE = 7;
    localparam int NET_SIDE   = MAX_DEGREE + 1;
    localparam int NET_DEPTH  = NET_SIDE * NET_SIDE;
    localparam int NET_AW     = $clog2(NET_DEPTH);
    localparam int WORK_DEPTH = 2 * NET_SIDE;
    localparam int WORK_AW    = $clog2(WORK_DEPTH);
    localparam int DEG_W      = $clog2(NET_SIDE);
    localparam int VAL_W      = 48;
    localparam int LANES      = 4;
    localparam int COORDS     = 3;
    localparam int DIV_CNT_W  = $clog2(VAL_W + 1);

    localparam logic       ACT_LOAD = 1'b0;
    localparam logic       ACT_EVAL = 1'b1;
    localparam logic [1:0] CFG_DEG_U    = 2'd0;
    localparam logic [1:0] CFG_DEG_V    = 2'd1;
    localparam logic [1:0] CFG_RATIONAL = 2'd2;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [15:0] ONE_Q12 = 16'd4096;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [31:0] t_word;
    typedef t_val  t_vec [LANES];
    typedef t_val  t_num [COORDS];
    typedef t_word t_res [COORDS];

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        w;
    } t_net;

    typedef enum logic [3:0] {
        S_IDLE, S_LRD, S_LWR, S_CRD0, S_CPREV, S_CRD, S_CGO, S_CP1, S_CWR,
        S_MRD, S_MWR, S_FRD, S_FCAP, S_DIV, S_OUT
    } t_state;

    function automatic t_word sat32(input t_val v);
        if (v > t_val'(64'sd2147483647)) begin
            return 32'h7fff_ffff;
        end else if (v < t_val'(-64'sd2147483648)) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// File: src/rbp_if.sv
`default_nettype none
interface rbp_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic signed [31:0] point_in_x;
    logic signed [31:0] point_in_y;
    logic signed [31:0] point_in_z;
    logic [15:0] point_weight;
    logic [16:0] param_u;
    logic [16:0] param_v;

    modport source (output valid, action, row_index, col_index, point_in_x, point_in_y,
                    point_in_z, point_weight, param_u, param_v, input ready);
    modport sink (input valid, action, row_index, col_index, point_in_x, point_in_y,
                  point_in_z, point_weight, param_u, param_v, output ready);
endinterface

interface rbp_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] surface_x;
    logic signed [31:0] surface_y;
    logic signed [31:0] surface_z;
    logic        zero_denominator;

    modport source (output valid, surface_x, surface_y, surface_z, zero_denominator,
                    input ready);
    modport sink (input valid, surface_x, surface_y, surface_z, zero_denominator,
                  output ready);
endinterface
`default_nettype wire

// File: src/rational_bezier_patch_evaluator.sv
// Channel  | Dir | Words
// i_in     | in  | load one control point, or evaluate the patch at (u, v)
// o_out    | out | one surface point for each evaluate word
// i_cfg_*  | in  | degree along u, degree along v, rational enable
// A load word is written into the net memory when it is accepted. The time from acceptance
// of an evaluate word to its result is set by the single read port of the work memory and
// the two-stage lerp unit; in rational mode the divider adds to it.
// Reset is synchronous and clears control state only; the net memory has no reset.
// The next word is taken while a result waits on a stalled output.
`default_nettype none
module rational_bezier_patch_evaluator (
    input  wire              i_clk,
    input  wire              i_rst_n,
    rbp_in_if.sink           i_in,
    rbp_out_if.source        o_out,
    input  wire              i_cfg_we,
    input  wire [1:0]        i_cfg_idx,
    input  wire [2:0]        i_cfg_data
);
    rbp_pkg::t_net  mem_net  [rbp_pkg::NET_DEPTH];
    rbp_pkg::t_vec  mem_work [rbp_pkg::WORK_DEPTH];

    rbp_pkg::t_state r_state, n_state;
    logic [2:0]  r_deg_u, r_deg_v;
    logic        r_rat;
    logic [rbp_pkg::DEG_W-1:0] r_du, r_dv, r_row, r_j, r_i, r_k;
    logic [rbp_pkg::DEG_W-1:0] n_row, n_j, n_i, n_k;
    logic        r_phase, n_phase;
    logic [16:0] r_tu, r_tv;
    rbp_pkg::t_net r_net_q;
    rbp_pkg::t_vec r_wq, r_prev, r_fin;
    logic        r_ovalid;
    rbp_pkg::t_word r_ox, r_oy, r_oz;
    logic        r_ozd;

    logic        in_acc, out_load;
    logic [rbp_pkg::NET_AW-1:0]  net_raddr;
    logic [rbp_pkg::WORK_AW-1:0] w_raddr, w_waddr, base;
    logic        w_we, lerp_go, div_start, div_done;
    rbp_pkg::t_vec w_wdata, lerp_res, scaled;
    rbp_pkg::t_num div_num;
    rbp_pkg::t_res div_res;
    logic [15:0] den;
    logic        den_zero;
    rbp_pkg::t_word res_x, res_y, res_z;

    assign in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == rbp_pkg::S_IDLE);
    assign base = r_phase ? rbp_pkg::WORK_AW'(rbp_pkg::NET_SIDE) : '0;
    assign den = r_fin[3][15:0];
    assign den_zero = (den == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_u <= 3'd3;
            r_deg_v <= 3'd3;
            r_rat   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbp_pkg::CFG_DEG_U:    r_deg_u <= i_cfg_data;
                rbp_pkg::CFG_DEG_V:    r_deg_v <= i_cfg_data;
                rbp_pkg::CFG_RATIONAL: r_rat   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.action == rbp_pkg::ACT_LOAD &&
            int'(i_in.row_index) <= rbp_pkg::MAX_DEGREE &&
            int'(i_in.col_index) <= rbp_pkg::MAX_DEGREE) begin
            mem_net[rbp_pkg::NET_AW'(int'(i_in.row_index) * rbp_pkg::NET_SIDE
                                     + int'(i_in.col_index))]
                <= '{x: i_in.point_in_x, y: i_in.point_in_y, z: i_in.point_in_z,
                     w: i_in.point_weight};
        end
        r_net_q <= mem_net[net_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_work[w_waddr] <= w_wdata;
        end
        r_wq <= mem_work[w_raddr];
    end

    always_comb begin
        scaled[0] = r_rat ? rbp_pkg::t_val'(r_net_q.x * $signed({1'b0, r_net_q.w}))
                          : rbp_pkg::t_val'(r_net_q.x);
        scaled[1] = r_rat ? rbp_pkg::t_val'(r_net_q.y * $signed({1'b0, r_net_q.w}))
                          : rbp_pkg::t_val'(r_net_q.y);
        scaled[2] = r_rat ? rbp_pkg::t_val'(r_net_q.z * $signed({1'b0, r_net_q.w}))
                          : rbp_pkg::t_val'(r_net_q.z);
        scaled[3] = rbp_pkg::t_val'({1'b0, r_net_q.w});
        for (int c = 0; c < rbp_pkg::COORDS; c++) begin
            div_num[c] = r_wq[c];
        end
    end

    rbp_lerp u_lerp (
        .i_clk (i_clk),
        .i_go  (lerp_go),
        .i_a   (r_prev),
        .i_b   (r_wq),
        .i_t   (r_phase ? r_tu : r_tv),
        .o_res (lerp_res)
    );

    rbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ((r_wq[3][15:0] == '0) ? rbp_pkg::ONE_Q12 : r_wq[3][15:0]),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_comb begin
        if (r_rat) begin
            res_x = div_res[0];
            res_y = div_res[1];
            res_z = div_res[2];
        end else begin
            res_x = rbp_pkg::sat32(r_fin[0]);
            res_y = rbp_pkg::sat32(r_fin[1]);
            res_z = rbp_pkg::sat32(r_fin[2]);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_j       = r_j;
        n_i       = r_i;
        n_k       = r_k;
        n_phase   = r_phase;
        net_raddr = rbp_pkg::NET_AW'(int'(r_row) * rbp_pkg::NET_SIDE + int'(r_j));
        w_raddr   = base;
        w_we      = 1'b0;
        w_waddr   = base + rbp_pkg::WORK_AW'(r_i);
        w_wdata   = lerp_res;
        lerp_go   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            rbp_pkg::S_IDLE: begin
                if (in_acc && i_in.action == rbp_pkg::ACT_EVAL) begin
                    n_row   = '0;
                    n_j     = '0;
                    n_phase = 1'b0;
                    n_state = rbp_pkg::S_LRD;
                end
            end
            rbp_pkg::S_LRD: n_state = rbp_pkg::S_LWR;
            rbp_pkg::S_LWR: begin
                w_we    = 1'b1;
                w_waddr = rbp_pkg::WORK_AW'(r_j);
                w_wdata = scaled;
                if (r_j == r_dv) begin
                    n_k     = r_dv;
                    n_i     = '0;
                    n_state = (r_dv == '0) ? rbp_pkg::S_MRD : rbp_pkg::S_CRD0;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = rbp_pkg::S_LRD;
                end
            end
            rbp_pkg::S_CRD0: begin
                n_i     = '0;
                n_state = rbp_pkg::S_CPREV;
            end
            rbp_pkg::S_CPREV: n_state = rbp_pkg::S_CRD;
            rbp_pkg::S_CRD: begin
                w_raddr = base + rbp_pkg::WORK_AW'(r_i) + 1'b1;
                n_state = rbp_pkg::S_CGO;
            end
            rbp_pkg::S_CGO: begin
                lerp_go = 1'b1;
                n_state = rbp_pkg::S_CP1;
            end
            rbp_pkg::S_CP1: n_state = rbp_pkg::S_CWR;
            rbp_pkg::S_CWR: begin
                w_we = 1'b1;
                if ({1'b0, r_i} + 1'b1 == {1'b0, r_k}) begin
                    if (r_k == rbp_pkg::DEG_W'(1)) begin
                        n_state = r_phase ? rbp_pkg::S_FRD : rbp_pkg::S_MRD;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = rbp_pkg::S_CRD0;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = rbp_pkg::S_CRD;
                end
            end
            rbp_pkg::S_MRD: begin
                w_raddr = '0;
                n_state = rbp_pkg::S_MWR;
            end
            rbp_pkg::S_MWR: begin
                w_we    = 1'b1;
                w_waddr = rbp_pkg::WORK_AW'(rbp_pkg::NET_SIDE + int'(r_row));
                w_wdata = r_wq;
                if (r_row == r_du) begin
                    n_phase = 1'b1;
                    n_k     = r_du;
                    n_state = (r_du == '0) ? rbp_pkg::S_FRD : rbp_pkg::S_CRD0;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_j     = '0;
                    n_state = rbp_pkg::S_LRD;
                end
            end
            rbp_pkg::S_FRD: begin
                w_raddr = rbp_pkg::WORK_AW'(rbp_pkg::NET_SIDE);
                n_state = rbp_pkg::S_FCAP;
            end
            rbp_pkg::S_FCAP: n_state = r_rat ? rbp_pkg::S_DIV : rbp_pkg::S_OUT;
            rbp_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = rbp_pkg::S_OUT;
                end
            end
            rbp_pkg::S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = rbp_pkg::S_IDLE;
                end
            end
            default: n_state = rbp_pkg::S_IDLE;
        endcase
        if (r_state == rbp_pkg::S_FCAP && r_rat) begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rbp_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_j   <= n_j;
        r_i   <= n_i;
        r_k   <= n_k;
        if (r_state == rbp_pkg::S_CPREV || r_state == rbp_pkg::S_CGO) begin
            r_prev <= r_wq;
        end
        if (r_state == rbp_pkg::S_FCAP) begin
            r_fin <= r_wq;
        end
        if (in_acc && i_in.action == rbp_pkg::ACT_EVAL) begin
            r_du <= (int'(r_deg_u) > rbp_pkg::MAX_DEGREE) ? rbp_pkg::DEG_W'(rbp_pkg::MAX_DEGREE)
                                                           : rbp_pkg::DEG_W'(r_deg_u);
            r_dv <= (int'(r_deg_v) > rbp_pkg::MAX_DEGREE) ? rbp_pkg::DEG_W'(rbp_pkg::MAX_DEGREE)
                                                           : rbp_pkg::DEG_W'(r_deg_v);
            r_tu <= (i_in.param_u > rbp_pkg::ONE_Q16) ? rbp_pkg::ONE_Q16 : i_in.param_u;
            r_tv <= (i_in.param_v > rbp_pkg::ONE_Q16) ? rbp_pkg::ONE_Q16 : i_in.param_v;
        end
        if (out_load) begin
            r_ox  <= res_x;
            r_oy  <= res_y;
            r_oz  <= res_z;
            r_ozd <= r_rat && den_zero;
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.surface_x        = r_ox;
    assign o_out.surface_y        = r_oy;
    assign o_out.surface_z        = r_oz;
    assign o_out.zero_denominator = r_ozd;

    a_lerp_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rbp_pkg::S_CWR |-> r_i < r_k)
        else $error("lerp index past level end");
    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == rbp_pkg::S_DIV)
        else $error("divider result outside its wait state");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_ovalid && r_state == rbp_pkg::S_IDLE)
        else $error("result not presented after evaluation");
    a_load_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rbp_pkg::S_LWR |-> r_j <= r_dv)
        else $error("row load past degree");
endmodule
`default_nettype wire

// File: src/rbp_lerp.sv
`default_nettype none
module rbp_lerp (
    input  wire               i_clk,
    input  wire               i_go,
    input  rbp_pkg::t_vec     i_a,
    input  rbp_pkg::t_vec     i_b,
    input  wire [16:0]        i_t,
    output rbp_pkg::t_vec     o_res
);
    logic signed [rbp_pkg::VAL_W:0]    r_d  [rbp_pkg::LANES];
    rbp_pkg::t_val                     r_a1 [rbp_pkg::LANES];
    rbp_pkg::t_val                     r_a2 [rbp_pkg::LANES];
    logic signed [rbp_pkg::VAL_W+18:0] r_p  [rbp_pkg::LANES];
    logic [16:0]                       r_t;
    logic signed [rbp_pkg::VAL_W+18:0] rnd  [rbp_pkg::LANES];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < rbp_pkg::LANES; c++) begin
            if (i_go) begin
                r_d[c]  <= (rbp_pkg::VAL_W+1)'(i_b[c]) - (rbp_pkg::VAL_W+1)'(i_a[c]);
                r_a1[c] <= i_a[c];
            end
            r_p[c]  <= r_d[c] * $signed({1'b0, r_t});
            r_a2[c] <= r_a1[c];
        end
        if (i_go) begin
            r_t <= i_t;
        end
    end

    always_comb begin
        for (int c = 0; c < rbp_pkg::LANES; c++) begin
            rnd[c]   = (r_p[c] + (rbp_pkg::VAL_W+19)'(32768)) >>> 16;
            o_res[c] = r_a2[c] + rnd[c][rbp_pkg::VAL_W-1:0];
        end
    end
endmodule
`default_nettype wire

// File: src/rbp_div.sv
`default_nettype none
module rbp_div (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  rbp_pkg::t_num  i_num,
    input  wire [15:0]     i_den,
    output logic           o_done,
    output rbp_pkg::t_res  o_res
);
    logic [rbp_pkg::VAL_W-1:0]     r_quo [rbp_pkg::COORDS];
    logic [15:0]                   r_rem [rbp_pkg::COORDS];
    logic                          r_neg [rbp_pkg::COORDS];
    logic [15:0]                   r_den;
    logic [rbp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [rbp_pkg::VAL_W-1:0]     mag   [rbp_pkg::COORDS];
    logic [16:0]                   rsh   [rbp_pkg::COORDS];
    logic                          qbit  [rbp_pkg::COORDS];

    always_comb begin
        for (int c = 0; c < rbp_pkg::COORDS; c++) begin
            mag[c]  = i_num[c][rbp_pkg::VAL_W-1] ? rbp_pkg::VAL_W'(-i_num[c])
                                                  : rbp_pkg::VAL_W'(i_num[c]);
            rsh[c]  = {r_rem[c], r_quo[c][rbp_pkg::VAL_W-1]};
            qbit[c] = (rsh[c] >= {1'b0, r_den});
            if (!r_neg[c]) begin
                o_res[c] = (r_quo[c] > rbp_pkg::VAL_W'(32'h7fff_ffff)) ? 32'h7fff_ffff
                                                                      : r_quo[c][31:0];
            end else begin
                o_res[c] = (r_quo[c] > rbp_pkg::VAL_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                                        : 32'(-r_quo[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rbp_pkg::DIV_CNT_W'(rbp_pkg::VAL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rbp_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int c = 0; c < rbp_pkg::COORDS; c++) begin
                r_quo[c] <= mag[c] + rbp_pkg::VAL_W'(i_den >> 1);
                r_rem[c] <= '0;
                r_neg[c] <= i_num[c][rbp_pkg::VAL_W-1];
            end
        end else if (r_busy) begin
            for (int c = 0; c < rbp_pkg::COORDS; c++) begin
                r_rem[c] <= qbit[c] ? 16'(rsh[c] - {1'b0, r_den}) : rsh[c][15:0];
                r_quo[c] <= {r_quo[c][rbp_pkg::VAL_W-2:0], qbit[c]};
            end
        end
    end

    assign o_done = r_done;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start |=> (r_cnt == $past(r_cnt) - 1'b1) || r_done)
        else $error("divider step count skipped");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_rem[0] < r_den)
        else $error("remainder not reduced");
endmodule
`default_nettype wire

// File: sim/rbp_scoreboard.sv
`default_nettype none
module rbp_scoreboard (
    input  wire   i_clk,
    input  wire   i_rst_n,
    rbp_in_if     in_w,
    rbp_out_if    out_w,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [2:0]  i_cfg_data,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        zd;
    } t_point;

    longint   pt_x [rbp_pkg::NET_DEPTH];
    longint   pt_y [rbp_pkg::NET_DEPTH];
    longint   pt_z [rbp_pkg::NET_DEPTH];
    longint   pt_w [rbp_pkg::NET_DEPTH];
    int       deg_u;
    int       deg_v;
    logic     rational;
    t_point   surface_q [$];
    int       fails;

    assign o_fail_count = fails;
    assign o_pending    = surface_q.size();

    function automatic longint blend(longint a, longint b, longint t);
        longint s;
        s = a * (64'sd65536 - t) + b * t + 64'sd32768;
        return s >>> 16;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_point surface_at(logic [16:0] pu, logic [16:0] pv);
        longint row [4][rbp_pkg::NET_SIDE];
        longint col [4][rbp_pkg::NET_SIDE];
        longint tu;
        longint tv;
        longint den;
        longint wgt;
        longint ch [3];
        t_point p;
        int a;
        tu = (pu > 17'd65536) ? 65536 : longint'(pu);
        tv = (pv > 17'd65536) ? 65536 : longint'(pv);
        for (int i = 0; i <= deg_u; i++) begin
            for (int j = 0; j <= deg_v; j++) begin
                a = i * rbp_pkg::NET_SIDE + j;
                wgt = pt_w[a];
                row[0][j] = rational ? pt_x[a] * wgt : pt_x[a];
                row[1][j] = rational ? pt_y[a] * wgt : pt_y[a];
                row[2][j] = rational ? pt_z[a] * wgt : pt_z[a];
                row[3][j] = wgt;
            end
            for (int c = 0; c < 4; c++) begin
                for (int k = deg_v; k > 0; k--) begin
                    for (int m = 0; m < k; m++) begin
                        row[c][m] = blend(row[c][m], row[c][m+1], tv);
                    end
                end
                col[c][i] = row[c][0];
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int k = deg_u; k > 0; k--) begin
                for (int m = 0; m < k; m++) begin
                    col[c][m] = blend(col[c][m], col[c][m+1], tu);
                end
            end
        end
        p.zd = 1'b0;
        den = col[3][0];
        for (int c = 0; c < 3; c++) begin
            if (!rational) begin
                ch[c] = col[c][0];
            end else if (den <= 0) begin
                ch[c] = round_div(col[c][0], 4096);
                p.zd = 1'b1;
            end else begin
                ch[c] = round_div(col[c][0], den);
            end
        end
        p.x = clamp32(ch[0]);
        p.y = clamp32(ch[1]);
        p.z = clamp32(ch[2]);
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: surface %s got %h expected %h", $realtime, what, got, want);
        fails++;
    endtask

    initial begin
        fails = 0;
    end

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            deg_u    <= 3;
            deg_v    <= 3;
            rational <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rbp_pkg::CFG_DEG_U:    deg_u    <= int'(i_cfg_data);
                    rbp_pkg::CFG_DEG_V:    deg_v    <= int'(i_cfg_data);
                    rbp_pkg::CFG_RATIONAL: rational <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_w.valid && in_w.ready) begin
                if (in_w.action == rbp_pkg::ACT_LOAD) begin
                    pt_x[in_w.row_index * rbp_pkg::NET_SIDE + in_w.col_index] = in_w.point_in_x;
                    pt_y[in_w.row_index * rbp_pkg::NET_SIDE + in_w.col_index] = in_w.point_in_y;
                    pt_z[in_w.row_index * rbp_pkg::NET_SIDE + in_w.col_index] = in_w.point_in_z;
                    pt_w[in_w.row_index * rbp_pkg::NET_SIDE + in_w.col_index] =
                        longint'(in_w.point_weight);
                end else begin
                    surface_q = {surface_q, surface_at(in_w.param_u, in_w.param_v)};
                end
            end
            if (out_w.valid && out_w.ready) begin
                if (surface_q.size() == 0) begin
                    report_mismatch("x with nothing expected", out_w.surface_x, 32'd0);
                end else begin
                    want = surface_q.pop_front();
                    if (out_w.surface_x !== want.x)
                        report_mismatch("x", out_w.surface_x, want.x);
                    if (out_w.surface_y !== want.y)
                        report_mismatch("y", out_w.surface_y, want.y);
                    if (out_w.surface_z !== want.z)
                        report_mismatch("z", out_w.surface_z, want.z);
                    if (out_w.zero_denominator !== want.zd)
                        report_mismatch("zero_denominator", {31'd0, out_w.zero_denominator},
                                        {31'd0, want.zd});
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: sim/rational_bezier_patch_evaluator_tb.sv
`default_nettype none
module rational_bezier_patch_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        act;
        logic [2:0]  r;
        logic [2:0]  c;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] w;
        logic [16:0] u;
        logic [16:0] v;
    } t_word_in;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [2:0] i_cfg_data;
    int         fail_count;
    int         pending;
    logic       calm;
    logic       hold_req;
    logic       hold_done;
    int         hold_cnt;

    rbp_in_if  in_ch ();
    rbp_out_if out_ch ();

    rational_bezier_patch_evaluator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    rbp_scoreboard checker_u (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_w        (in_ch),
        .out_w       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= 0;
            hold_done    <= 1'b0;
        end else if (hold_cnt > 0) begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= 4000;
            hold_done    <= 1'b1;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= 36);
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(131071) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hffff;
            2: return rbp_pkg::ONE_Q12;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [16:0] pick_param();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return rbp_pkg::ONE_Q16;
            2: return 17'(rbp_pkg::ONE_Q16 + $urandom_range(1, 65535));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic send_word(t_word_in wd);
        while (!calm && $urandom_range(99) < 36) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= wd.act;
        in_ch.row_index    <= wd.r;
        in_ch.col_index    <= wd.c;
        in_ch.point_in_x   <= wd.x;
        in_ch.point_in_y   <= wd.y;
        in_ch.point_in_z   <= wd.z;
        in_ch.point_weight <= wd.w;
        in_ch.param_u      <= wd.u;
        in_ch.param_v      <= wd.v;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
    endtask

    task automatic load_point(int r, int c, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [15:0] w);
        t_word_in wd;
        wd.act = rbp_pkg::ACT_LOAD;
        wd.r = 3'(r);
        wd.c = 3'(c);
        wd.x = x;
        wd.y = y;
        wd.z = z;
        wd.w = w;
        wd.u = 17'($urandom);
        wd.v = 17'($urandom);
        send_word(wd);
    endtask

    task automatic evaluate(logic [16:0] u, logic [16:0] v);
        t_word_in wd;
        wd.act = rbp_pkg::ACT_EVAL;
        wd.r = 3'($urandom);
        wd.c = 3'($urandom);
        wd.x = $urandom;
        wd.y = $urandom;
        wd.z = $urandom;
        wd.w = 16'($urandom);
        wd.u = u;
        wd.v = v;
        send_word(wd);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (1300) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [2:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_patch(int du, int dv, logic rat);
        write_cfg(rbp_pkg::CFG_DEG_U, 3'(du));
        write_cfg(rbp_pkg::CFG_DEG_V, 3'(dv));
        write_cfg(rbp_pkg::CFG_RATIONAL, {2'b00, rat});
    endtask

    task automatic random_phase(int du, int dv, logic rat, int count);
        drain();
        set_patch(du, dv, rat);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1)) begin
                evaluate(pick_param(), pick_param());
            end else begin
                load_point($urandom_range(7), $urandom_range(7), pick_coord(), pick_coord(),
                           pick_coord(), pick_weight());
            end
        end
    endtask

    initial begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        calm               <= 1'b0;
        hold_req           <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= rbp_pkg::CFG_DEG_U;
        i_cfg_data         <= 3'd0;
        in_ch.valid        <= 1'b0;
        in_ch.action       <= rbp_pkg::ACT_LOAD;
        in_ch.row_index    <= 3'd0;
        in_ch.col_index    <= 3'd0;
        in_ch.point_in_x   <= 32'd0;
        in_ch.point_in_y   <= 32'd0;
        in_ch.point_in_z   <= 32'd0;
        in_ch.point_weight <= 16'd0;
        in_ch.param_u      <= 17'd0;
        in_ch.param_v      <= 17'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                load_point(r, c, (r + c) % 2 ? 32'h7fff_ffff : 32'h8000_0000,
                           32'h0001_0000 * r, -32'sh0001_0000 * c, 16'hffff);
            end
        end
        evaluate(17'd0, 17'd0);
        evaluate(rbp_pkg::ONE_Q16, rbp_pkg::ONE_Q16);
        evaluate(17'h1ffff, 17'd32768);
        evaluate(17'd32768, rbp_pkg::ONE_Q16 + 17'd1);

        drain();
        set_patch(1, 1, 1'b1);
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
                load_point(r, c, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 16'd0);
            end
        end
        evaluate(17'd12345, 17'd54321);
        load_point(0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_8000, 16'd1);
        evaluate(17'd0, 17'd0);
        evaluate(17'd100, 17'd100);

        for (int a = 0; a < rbp_pkg::NET_DEPTH; a++) begin
            load_point(a / rbp_pkg::NET_SIDE, a % rbp_pkg::NET_SIDE, pick_coord(),
                       pick_coord(), pick_coord(), pick_weight());
        end

        random_phase(0, 0, 1'b0, 90);
        random_phase(2, 5, 1'b1, 90);
        calm <= 1'b1;
        random_phase(3, 1, 1'b0, 80);
        calm <= 1'b0;
        hold_req <= 1'b1;
        random_phase(1, 3, 1'b1, 90);
        random_phase(7, 7, 1'b1, 30);
        random_phase(7, 0, 1'b0, 70);
        random_phase(0, 7, 1'b1, 70);
        random_phase(5, 2, 1'b0, 70);
        random_phase(7, 7, 1'b0, 20);
        random_phase(0, 0, 1'b1, 90);

        drain();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
